// ===== rtl/core/svr_pkg.sv =====
// ============================================================================
// svr_pkg
// Shared types and constants of the stable value ranker.
// ============================================================================
package svr_pkg;

    localparam int VALUE_W  = 32;
    localparam int RANK_W   = 7;
    localparam int QDEPTH   = 4;
    localparam int QPTR_W   = 2;
    localparam int QCNT_W   = 3;
    localparam int GROUP_W  = 8;
    localparam int GCNT_W   = 4;

    // One input item as it travels from the front to the back.
    typedef struct packed {
        logic signed [VALUE_W-1:0] value;
        logic                      last;
    } item_t;

    // Commands from the sequencer to the rank cell row.
    typedef struct packed {
        logic                      store;
        logic                      shift;
        logic signed [VALUE_W-1:0] key;
    } cell_ctrl_t;

endpackage

// ===== rtl/core/svr_front.sv =====
// ============================================================================
// svr_front
// Input side: accepts stream transfers into a short queue for the back end.
// ============================================================================
module svr_front
    import svr_pkg::*;
(
    input  logic                clk,
    input  logic                rst_n,
    input  logic                in_valid,
    output logic                in_ready,
    input  logic [VALUE_W-1:0]  in_value,
    input  logic                in_last,
    output logic                q_valid,
    output item_t               q_item,
    input  logic                q_pop
);

    item_t              mem_reg [QDEPTH];
    logic [QPTR_W-1:0]  wr_ptr_reg;
    logic [QPTR_W-1:0]  wr_ptr_next;
    logic [QPTR_W-1:0]  rd_ptr_reg;
    logic [QPTR_W-1:0]  rd_ptr_next;
    logic [QCNT_W-1:0]  fill_reg;
    logic [QCNT_W-1:0]  fill_next;
    logic               push;
    logic               pop;

    assign in_ready = (fill_reg != QCNT_W'(QDEPTH));
    assign push     = in_valid && in_ready;
    assign q_valid  = (fill_reg != '0);
    assign pop      = q_pop && q_valid;
    assign q_item   = mem_reg[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = push ? wr_ptr_reg + 1'b1 : wr_ptr_reg;
        rd_ptr_next = pop ? rd_ptr_reg + 1'b1 : rd_ptr_reg;
        fill_next   = fill_reg + QCNT_W'(push) - QCNT_W'(pop);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            fill_reg   <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            fill_reg   <= fill_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            mem_reg[wr_ptr_reg].value <= $signed(in_value);
            mem_reg[wr_ptr_reg].last  <= in_last;
        end
    end

endmodule

// ===== rtl/core/svr_cells.sv =====
// ============================================================================
// svr_cells
// Row of rank cells with a registered count tree for the rank of a new value.
// ============================================================================
module svr_cells
    import svr_pkg::*;
#(
    parameter int MAX_ITEMS = 64
)
(
    input  logic                               clk,
    input  logic                               rst_n,
    input  cell_ctrl_t                         ctrl,
    input  logic [$clog2(MAX_ITEMS+1)-1:0]     count,
    output logic                               busy,
    output logic [RANK_W-1:0]                  rank0
);

    localparam int CNTW = $clog2(MAX_ITEMS + 1);
    localparam int IW   = $clog2(MAX_ITEMS);
    localparam int NG   = (MAX_ITEMS + GROUP_W - 1) / GROUP_W;

    logic signed [VALUE_W-1:0] val_reg  [MAX_ITEMS];
    logic [RANK_W-1:0]         rank_reg [MAX_ITEMS];
    logic [NG*GROUP_W-1:0]     le_vec;
    logic [GCNT_W-1:0]         grp_sum  [NG];
    logic [GCNT_W-1:0]         s1_grp_reg [NG];
    logic                      s1_valid_reg;
    logic [IW-1:0]             s1_idx_reg;
    logic [RANK_W-1:0]         s2_total_next;
    logic [RANK_W-1:0]         s2_total_reg;
    logic                      s2_valid_reg;
    logic [IW-1:0]             s2_idx_reg;

    // Compare the incoming key against every live cell.
    always_comb
    begin
        le_vec = '0;
        for (int i = 0; i < MAX_ITEMS; i++)
        begin
            le_vec[i] = (CNTW'(i) < count) && (val_reg[i] <= ctrl.key);
        end
    end

    always_comb
    begin
        for (int g = 0; g < NG; g++)
        begin
            grp_sum[g] = '0;
            for (int j = 0; j < GROUP_W; j++)
            begin
                grp_sum[g] = grp_sum[g] + GCNT_W'(le_vec[g*GROUP_W+j]);
            end
        end
    end

    always_comb
    begin
        s2_total_next = '0;
        for (int g = 0; g < NG; g++)
        begin
            s2_total_next = s2_total_next + RANK_W'(s1_grp_reg[g]);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
            s2_valid_reg <= 1'b0;
        end
        else
        begin
            s1_valid_reg <= ctrl.store;
            s2_valid_reg <= s1_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        for (int g = 0; g < NG; g++)
        begin
            s1_grp_reg[g] <= grp_sum[g];
        end
        s1_idx_reg   <= count[IW-1:0];
        s2_total_reg <= s2_total_next;
        s2_idx_reg   <= s1_idx_reg;
    end

    for (genvar i = 0; i < MAX_ITEMS; i++)
    begin : g_cell
        logic              inc;
        logic [RANK_W-1:0] add;
        logic [RANK_W-1:0] shift_in;
        logic [RANK_W-1:0] rank_next;

        if (i < MAX_ITEMS - 1)
        begin : g_mid
            assign shift_in = rank_reg[i+1];
        end
        else
        begin : g_end
            assign shift_in = rank_reg[i];
        end

        // A larger value moves up by one; the count tree adds the earlier
        // smaller-or-equal values to the rank of the cell it belongs to.
        always_comb
        begin
            inc = ctrl.store && (CNTW'(i) < count) && (val_reg[i] > ctrl.key);
            add = (s2_valid_reg && (s2_idx_reg == IW'(i))) ? s2_total_reg : '0;
            priority if (ctrl.shift)
            begin
                rank_next = shift_in;
            end
            else if (ctrl.store && (count[IW-1:0] == IW'(i)))
            begin
                rank_next = RANK_W'(1);
            end
            else
            begin
                rank_next = rank_reg[i] + RANK_W'(inc) + add;
            end
        end

        always_ff @(posedge clk)
        begin
            rank_reg[i] <= rank_next;
            if (ctrl.store && (count[IW-1:0] == IW'(i)))
            begin
                val_reg[i] <= ctrl.key;
            end
        end
    end

    assign busy  = s1_valid_reg || s2_valid_reg;
    assign rank0 = rank_reg[0];

endmodule

// ===== rtl/core/svr_back.sv =====
// ============================================================================
// svr_back
// Sequencer: takes queued items, drives the cell row and emits the ranks.
// ============================================================================
module svr_back
    import svr_pkg::*;
#(
    parameter int MAX_ITEMS = 64
)
(
    input  logic                               clk,
    input  logic                               rst_n,
    input  logic                               q_valid,
    input  item_t                              q_item,
    output logic                               q_pop,
    output cell_ctrl_t                         ctrl,
    output logic [$clog2(MAX_ITEMS+1)-1:0]     count,
    input  logic                               busy,
    input  logic [RANK_W-1:0]                  rank0,
    output logic                               out_valid,
    input  logic                               out_ready,
    output logic [RANK_W-1:0]                  out_rank,
    output logic                               out_overflow,
    output logic                               out_last
);

    localparam int CNTW = $clog2(MAX_ITEMS + 1);

    localparam logic [1:0] ST_RUN  = 2'd0;
    localparam logic [1:0] ST_WAIT = 2'd1;
    localparam logic [1:0] ST_EMIT = 2'd2;

    logic [1:0]         state_reg;
    logic [1:0]         state_next;
    logic [CNTW-1:0]    count_reg;
    logic [CNTW-1:0]    count_next;
    logic               ovf_reg;
    logic               ovf_next;
    logic               out_valid_reg;
    logic               out_valid_next;
    logic [RANK_W-1:0]  out_rank_reg;
    logic               out_ovf_reg;
    logic               out_last_reg;
    logic               out_load;
    logic               full;

    assign full     = (count_reg == CNTW'(MAX_ITEMS));
    assign q_pop    = (state_reg == ST_RUN);
    assign out_load = (state_reg == ST_EMIT) && (!out_valid_reg || out_ready);

    always_comb
    begin
        ctrl.store = (state_reg == ST_RUN) && q_valid && !full;
        ctrl.shift = out_load;
        ctrl.key   = q_item.value;
    end

    always_comb
    begin
        state_next     = state_reg;
        count_next     = count_reg;
        ovf_next       = ovf_reg;
        out_valid_next = out_valid_reg;
        if (out_valid_reg && out_ready)
        begin
            out_valid_next = 1'b0;
        end
        unique case (state_reg)
            ST_RUN:
            begin
                if (q_valid)
                begin
                    if (full)
                    begin
                        ovf_next = 1'b1;
                    end
                    else
                    begin
                        count_next = count_reg + 1'b1;
                    end
                    if (q_item.last)
                    begin
                        state_next = ST_WAIT;
                    end
                end
            end
            ST_WAIT:
            begin
                if (!busy)
                begin
                    state_next = ST_EMIT;
                end
            end
            ST_EMIT:
            begin
                if (out_load)
                begin
                    out_valid_next = 1'b1;
                    count_next     = count_reg - 1'b1;
                    if (count_reg == CNTW'(1))
                    begin
                        ovf_next   = 1'b0;
                        state_next = ST_RUN;
                    end
                end
            end
            default:
            begin
                state_next = ST_RUN;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_RUN;
            count_reg     <= '0;
            ovf_reg       <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            count_reg     <= count_next;
            ovf_reg       <= ovf_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (out_load)
        begin
            out_rank_reg <= rank0;
            out_ovf_reg  <= ovf_reg;
            out_last_reg <= (count_reg == CNTW'(1));
        end
    end

    assign count        = count_reg;
    assign out_valid    = out_valid_reg;
    assign out_rank     = out_rank_reg;
    assign out_overflow = out_ovf_reg;
    assign out_last     = out_last_reg;

`ifndef SYNTHESIS
    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= CNTW'(MAX_ITEMS))
        else $error("svr_back: item count above capacity");

    a_ovf_full: assert property (@(posedge clk) disable iff (!rst_n)
        (ovf_reg && (state_reg != ST_EMIT)) |-> full)
        else $error("svr_back: overflow set with room left");

    a_emit_idle: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_EMIT) |-> !busy)
        else $error("svr_back: rank update in flight while emitting");

    a_last_done: assert property (@(posedge clk) disable iff (!rst_n)
        (out_load && (count_reg == CNTW'(1))) |=> (state_reg == ST_RUN) && !ovf_reg)
        else $error("svr_back: sequence not closed after final rank");
`endif

endmodule

// ===== rtl/core/stable_value_ranker_core.sv =====
// After the transfer that carries tlast, the first rank leaves once the count
// tree has drained, then one rank per cycle while the output side takes them.
// One value is taken per cycle while a sequence streams in, set by the
// compare cell row; the output side drains one rank per kept value.
// Reset clears the queue, the sequencer and the output valid; stored values
// and ranks are not cleared and are only read after being written.
// ============================================================================
// stable_value_ranker_core
// Stable ranker of signed 32-bit values, results in input order.
// ============================================================================
//
// The front end holds incoming transfers in a four-entry queue. The back end
// pops one value per cycle, while it collects a sequence, into a row of
// compare cells. Every live cell whose value is larger than the new one bumps
// its own rank, and a two-stage registered count tree sums the cells that are
// smaller or equal; its second stage adds that sum to the new cell's rank.
// When the value marked by tlast has been taken, the sequencer waits for the
// tree to drain and then shifts the ranks out of the row, first stored value
// first. Values that arrive while the row is full are dropped and flag
// overflow on every result of that sequence.
module stable_value_ranker_core
    import svr_pkg::*;
#(
    parameter int MAX_ITEMS = 64
)
(
    input  logic         clk,
    input  logic         rst_n,
    input  logic         s_axis_tvalid,
    output logic         s_axis_tready,
    input  logic [31:0]  s_axis_tdata,   // [31:0] value (signed)
    input  logic         s_axis_tlast,   // last_item
    output logic         m_axis_tvalid,
    input  logic         m_axis_tready,
    output logic [7:0]   m_axis_tdata,   // [6:0] rank, [7] zero fill
    output logic         m_axis_tuser,   // [0] overflow
    output logic         m_axis_tlast    // last_result
);

    localparam int CNTW = $clog2(MAX_ITEMS + 1);

    logic               q_valid;
    item_t              q_item;
    logic               q_pop;
    cell_ctrl_t         ctrl;
    logic [CNTW-1:0]    count;
    logic               busy;
    logic [RANK_W-1:0]  rank0;
    logic [RANK_W-1:0]  out_rank;

    svr_front u_front
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (s_axis_tvalid),
        .in_ready (s_axis_tready),
        .in_value (s_axis_tdata),
        .in_last  (s_axis_tlast),
        .q_valid  (q_valid),
        .q_item   (q_item),
        .q_pop    (q_pop)
    );

    svr_cells #(.MAX_ITEMS(MAX_ITEMS)) u_cells
    (
        .clk   (clk),
        .rst_n (rst_n),
        .ctrl  (ctrl),
        .count (count),
        .busy  (busy),
        .rank0 (rank0)
    );

    svr_back #(.MAX_ITEMS(MAX_ITEMS)) u_back
    (
        .clk          (clk),
        .rst_n        (rst_n),
        .q_valid      (q_valid),
        .q_item       (q_item),
        .q_pop        (q_pop),
        .ctrl         (ctrl),
        .count        (count),
        .busy         (busy),
        .rank0        (rank0),
        .out_valid    (m_axis_tvalid),
        .out_ready    (m_axis_tready),
        .out_rank     (out_rank),
        .out_overflow (m_axis_tuser),
        .out_last     (m_axis_tlast)
    );

    assign m_axis_tdata = {1'b0, out_rank};

endmodule
